// File: rtl/core/dependent_watermark_tracker_unit_macros.svh
// ---------------------------------------------------------------------------
// Watermark tracker assertion macros
// Clocked assertion shorthands shared by the tracker RTL.
// ---------------------------------------------------------------------------
`ifndef DEPENDENT_WATERMARK_TRACKER_UNIT_MACROS_SVH
`define DEPENDENT_WATERMARK_TRACKER_UNIT_MACROS_SVH

// same-cycle implication
`define DWT_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("watermark tracker check failed");

// next-cycle implication
`define DWT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("watermark tracker check failed");

`endif

// File: rtl/core/dwt_pkg.sv
// ---------------------------------------------------------------------------
// Watermark tracker package
// Position type, watermark selectors, order and error codes.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package dwt_pkg;

    localparam int WM_COUNT = 4;
    localparam int FIELD_W  = 64;

    typedef enum logic [1:0] {
        OP_VISIBLE    = 2'd0,
        OP_DURABLE    = 2'd1,
        OP_PROJECTION = 2'd2,
        OP_REPLICATED = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ORD_UNORDERED = 2'd0,
        ORD_BEFORE    = 2'd1,
        ORD_EQUAL     = 2'd2,
        ORD_AFTER     = 2'd3
    } ord_t;

    typedef enum logic [2:0] {
        ERR_NONE    = 3'd0,
        ERR_EPOCH   = 3'd1,
        ERR_REGRESS = 3'd2,
        ERR_UNSET   = 3'd3,
        ERR_AHEAD   = 3'd4
    } err_t;

    typedef struct packed {
        logic [FIELD_W-1:0] frame;
        logic [FIELD_W-1:0] sequence_num;
        logic [FIELD_W-1:0] epoch;
        logic [FIELD_W-1:0] stream;
    } pos_t;

    // order of a relative to b
    function automatic ord_t order_of(input pos_t a, input pos_t b);
        ord_t o;
        if ((a.stream != b.stream) || (a.epoch != b.epoch))
        begin
            o = ORD_UNORDERED;
        end
        else if (a.sequence_num < b.sequence_num)
        begin
            o = ORD_BEFORE;
        end
        else if (a.sequence_num > b.sequence_num)
        begin
            o = ORD_AFTER;
        end
        else if (a.frame == b.frame)
        begin
            o = ORD_EQUAL;
        end
        else
        begin
            o = ORD_UNORDERED;
        end
        return o;
    endfunction

endpackage

// File: rtl/core/dependent_watermark_tracker_unit.sv
// ---------------------------------------------------------------------------
// Dependent watermark tracker
// Keeps visible, durable, projection and replicated watermarks and checks
// each offered position against its dependency before advancing.
// ---------------------------------------------------------------------------
// Usage:
//   s_axis carries one offered position per item; tuser selects the
//   watermark (0 visible, 1 durable, 2 projection, 3 replicated).
//   m_axis returns one result item per input item, in order.
// Path: input register, then compare/update logic into the result register.
// Throughput: one item per cycle while the output is not stalled; the
//   watermark registers are updated on the same edge that loads the result,
//   so the next item sees them.
// Reset: all watermarks become unset, both stages empty.
// Stall: while m_axis_tready is low the result register holds; one more
//   item may wait in the input register, after which s_axis_tready drops.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module dependent_watermark_tracker_unit
    import dwt_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,

    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // [63:0] position_stream, [127:64] position_epoch,
    // [191:128] position_sequence, [255:192] position_frame
    input  logic [255:0] s_axis_tdata,
    // [1:0] op
    input  logic [1:0]   s_axis_tuser,

    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [0] advanced, [3:1] error_code, [7:4] zero
    output logic [7:0]   m_axis_tdata
);

`include "dependent_watermark_tracker_unit_macros.svh"

    logic                in_valid_reg;
    logic                in_valid_next;
    op_t                 in_op_reg;
    pos_t                in_pos_reg;

    logic                out_valid_reg;
    logic                out_valid_next;
    logic                out_adv_reg;
    err_t                out_err_reg;

    logic [WM_COUNT-1:0] mark_valid_reg;
    pos_t                mark_pos_reg [WM_COUNT];

    logic                in_fire;
    logic                step_fire;
    ord_t                ord_vs [WM_COUNT];
    ord_t                dep_ord;
    logic                dep_valid;
    err_t                chk_err;
    logic                adv_next;
    err_t                err_next;

    assign step_fire     = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || step_fire;
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    assign in_valid_next  = in_fire ? 1'b1 : (step_fire ? 1'b0 : in_valid_reg);
    assign out_valid_next = step_fire ? 1'b1 : (m_axis_tready ? 1'b0 : out_valid_reg);

    // stored mark relative to the offered position
    genvar g;
    generate
        for (g = 0; g < WM_COUNT; g++)
        begin : g_cmp
            assign ord_vs[g] = order_of(mark_pos_reg[g], in_pos_reg);
        end
    endgenerate

    always_comb
    begin
        unique case (in_op_reg)
            OP_VISIBLE:
            begin
                dep_valid = 1'b1;
                dep_ord   = ORD_EQUAL;
            end
            OP_DURABLE:
            begin
                dep_valid = mark_valid_reg[OP_VISIBLE];
                dep_ord   = ord_vs[OP_VISIBLE];
            end
            OP_PROJECTION, OP_REPLICATED:
            begin
                dep_valid = mark_valid_reg[OP_DURABLE];
                dep_ord   = ord_vs[OP_DURABLE];
            end
            default:
            begin
                dep_valid = 1'b1;
                dep_ord   = ORD_EQUAL;
            end
        endcase
    end

    // dependency stored before offered means offered is ahead
    always_comb
    begin
        priority if (!dep_valid)
        begin
            chk_err = ERR_UNSET;
        end
        else if (dep_ord == ORD_UNORDERED)
        begin
            chk_err = ERR_EPOCH;
        end
        else if (dep_ord == ORD_BEFORE)
        begin
            chk_err = ERR_AHEAD;
        end
        else
        begin
            chk_err = ERR_NONE;
        end
    end

    always_comb
    begin
        adv_next = 1'b0;
        err_next = ERR_NONE;
        if (chk_err != ERR_NONE)
        begin
            err_next = chk_err;
        end
        else if (!mark_valid_reg[in_op_reg])
        begin
            adv_next = 1'b1;
        end
        else
        begin
            unique case (ord_vs[in_op_reg])
                ORD_BEFORE:    adv_next = 1'b1;
                ORD_EQUAL:     err_next = ERR_NONE;
                ORD_AFTER:     err_next = ERR_REGRESS;
                ORD_UNORDERED: err_next = ERR_EPOCH;
                default:       err_next = ERR_EPOCH;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            mark_valid_reg <= '0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (step_fire && adv_next)
            begin
                mark_valid_reg[in_op_reg] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            in_op_reg  <= op_t'(s_axis_tuser);
            in_pos_reg <= pos_t'({s_axis_tdata[255:192], s_axis_tdata[191:128],
                                  s_axis_tdata[127:64], s_axis_tdata[63:0]});
        end
        if (step_fire)
        begin
            out_adv_reg <= adv_next;
            out_err_reg <= err_next;
            if (adv_next)
            begin
                mark_pos_reg[in_op_reg] <= in_pos_reg;
            end
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'b0000, out_err_reg, out_adv_reg};

    `DWT_ASSERT_NOW(a_adv_no_err, out_valid_reg && out_adv_reg, out_err_reg == ERR_NONE)
    `DWT_ASSERT_NEXT(a_adv_sets_valid, step_fire && adv_next, mark_valid_reg[$past(in_op_reg)])
    `DWT_ASSERT_NEXT(a_valid_sticky, 1'b1, ($past(mark_valid_reg) & ~mark_valid_reg) == '0)
    `DWT_ASSERT_NOW(a_durable_needs_visible, mark_valid_reg[OP_DURABLE],
                    mark_valid_reg[OP_VISIBLE])
    `DWT_ASSERT_NOW(a_lower_needs_durable,
                    mark_valid_reg[OP_PROJECTION] || mark_valid_reg[OP_REPLICATED],
                    mark_valid_reg[OP_DURABLE])

endmodule

// File: test/dwt_result_checker.sv
// ---------------------------------------------------------------------------
// Watermark tracker result checker
// Watches both stream channels of the tracker, keeps its own copy of the four
// watermarks, predicts the outcome of every accepted position and compares
// each returned item field by field against the oldest prediction.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module dwt_result_checker
    import dwt_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,

    input  logic         s_axis_tvalid,
    input  logic         s_axis_tready,
    input  logic [255:0] s_axis_tdata,
    input  logic [1:0]   s_axis_tuser,

    input  logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    input  logic [7:0]   m_axis_tdata,

    output int           fail_count,
    output int           open_count,
    output int           offer_count,
    output int           advance_count,
    output int           refusal_count
);

    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic advanced;
        err_t error_code;
    } outcome_t;

    logic     wm_set [WM_COUNT];
    pos_t     wm_at [WM_COUNT];
    outcome_t outcome_due [$];

    // where a stands relative to b
    function automatic ord_t compare_pos(input pos_t a, input pos_t b);
        if ((a.stream != b.stream) || (a.epoch != b.epoch))
        begin
            return ORD_UNORDERED;
        end
        if (a.sequence_num < b.sequence_num)
        begin
            return ORD_BEFORE;
        end
        if (a.sequence_num > b.sequence_num)
        begin
            return ORD_AFTER;
        end
        return (a.frame == b.frame) ? ORD_EQUAL : ORD_UNORDERED;
    endfunction

    // dependency check, then forward-only advance of the named watermark
    function automatic outcome_t track_offer(input op_t op, input pos_t p);
        outcome_t res;
        op_t      dep;
        ord_t     o;
        logic     take;
        res.advanced   = 1'b0;
        res.error_code = ERR_NONE;
        take           = 1'b0;
        if (op != OP_VISIBLE)
        begin
            dep = (op == OP_DURABLE) ? OP_VISIBLE : OP_DURABLE;
            if (!wm_set[dep])
            begin
                res.error_code = ERR_UNSET;
            end
            else
            begin
                o = compare_pos(p, wm_at[dep]);
                if (o == ORD_UNORDERED)
                begin
                    res.error_code = ERR_EPOCH;
                end
                else if (o == ORD_AFTER)
                begin
                    res.error_code = ERR_AHEAD;
                end
            end
        end
        if (res.error_code == ERR_NONE)
        begin
            if (!wm_set[op])
            begin
                take = 1'b1;
            end
            else
            begin
                o = compare_pos(wm_at[op], p);
                case (o)
                    ORD_BEFORE: take = 1'b1;
                    ORD_EQUAL:  take = 1'b0;
                    ORD_AFTER:  res.error_code = ERR_REGRESS;
                    default:    res.error_code = ERR_EPOCH;
                endcase
            end
        end
        if (take)
        begin
            wm_set[op]   = 1'b1;
            wm_at[op]    = p;
            res.advanced = 1'b1;
        end
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        outcome_t got;
        outcome_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < WM_COUNT; i++)
            begin
                wm_set[i] = 1'b0;
                wm_at[i]  = '0;
            end
            outcome_due.delete();
            fail_count    = 0;
            open_count    = 0;
            offer_count   = 0;
            advance_count = 0;
            refusal_count = 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                want = track_offer(op_t'(s_axis_tuser), pos_t'(s_axis_tdata));
                outcome_due.insert(outcome_due.size(), want);
                offer_count++;
                if (want.advanced)
                begin
                    advance_count++;
                end
                if (want.error_code != ERR_NONE)
                begin
                    refusal_count++;
                end
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.advanced   = m_axis_tdata[0];
                got.error_code = err_t'(m_axis_tdata[3:1]);
                if (outcome_due.size() == 0)
                begin
                    if (fail_count < REPORT_LIMIT)
                    begin
                        $display("%0t: unexpected result item, tdata %h", $realtime,
                                 m_axis_tdata);
                    end
                    fail_count++;
                end
                else
                begin
                    want = outcome_due.pop_front();
                    if ((got.advanced !== want.advanced) ||
                        (got.error_code !== want.error_code))
                    begin
                        if (fail_count < REPORT_LIMIT)
                        begin
                            $display("%0t: mismatch: advanced exp %0b got %0b, error exp %0d got %0d",
                                     $realtime, want.advanced, got.advanced,
                                     want.error_code, got.error_code);
                        end
                        fail_count++;
                    end
                end
            end
            open_count = outcome_due.size();
        end
    end

endmodule

// File: test/dependent_watermark_tracker_unit_tb.sv
// ---------------------------------------------------------------------------
// Watermark tracker testbench
// Drives offered positions into the tracker: a directed walk through unset
// dependencies, first sets, equal, regressing, unordered and ahead positions,
// then random offers that mostly follow one stream and epoch with a slowly
// rising sequence, mixed with foreign streams, epochs and frames. Both sides
// stall at random, with one calm stretch. A separate checker predicts results.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module dependent_watermark_tracker_unit_tb
    import dwt_pkg::*;
();

    localparam int RANDOM_OFFERS = 2000;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int DRAIN_CYCLES  = 10;

    logic         clk;
    logic         rst_n          = 1'b0;
    logic         s_axis_tvalid  = 1'b0;
    logic         s_axis_tready;
    logic [255:0] s_axis_tdata   = '0;
    logic [1:0]   s_axis_tuser   = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready  = 1'b0;
    logic [7:0]   m_axis_tdata;

    logic         steady         = 1'b0;
    int           cycle_count    = 0;
    int           fail_count;
    int           open_count;
    int           offer_count;
    int           advance_count;
    int           refusal_count;

    logic [63:0]  ctx_stream;
    logic [63:0]  ctx_epoch;
    logic [63:0]  ctx_key;
    logic [63:0]  ctx_base;

    dependent_watermark_tracker_unit i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    dwt_result_checker i_result_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .fail_count    (fail_count),
        .open_count    (open_count),
        .offer_count   (offer_count),
        .advance_count (advance_count),
        .refusal_count (refusal_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        m_axis_tready <= steady || ($urandom_range(0, 99) >= 19);
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("dependent_watermark_tracker_unit_tb failed");
            $finish;
        end
    end

    // position in the main stream, frame tied to sequence
    function automatic pos_t ctx_pos(input int step);
        pos_t p;
        p.stream       = ctx_stream;
        p.epoch        = ctx_epoch;
        p.sequence_num = ctx_base + 64'(step);
        p.frame        = p.sequence_num ^ ctx_key;
        return p;
    endfunction

    task automatic offer(input op_t op, input pos_t p);
        while (!steady && ($urandom_range(0, 99) < 19))
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= p;
        s_axis_tuser  <= op;
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    initial
    begin : stimulus
        pos_t        p;
        op_t         op;
        int          front;
        int          step;
        int          roll;

        ctx_stream = {$urandom, $urandom};
        ctx_epoch  = {$urandom, $urandom};
        ctx_key    = {$urandom, $urandom};
        ctx_base   = {2'b00, 30'($urandom), $urandom};

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // dependencies unset
        offer(OP_DURABLE, ctx_pos(5));
        offer(OP_PROJECTION, ctx_pos(5));
        offer(OP_REPLICATED, ctx_pos(5));
        // visible: first set, equal, regression, unordered
        offer(OP_VISIBLE, ctx_pos(10));
        offer(OP_VISIBLE, ctx_pos(10));
        offer(OP_VISIBLE, ctx_pos(5));
        p = ctx_pos(10);
        p.frame = ~p.frame;
        offer(OP_VISIBLE, p);
        p = ctx_pos(12);
        p.epoch = '1;
        offer(OP_VISIBLE, p);
        p = ctx_pos(12);
        p.stream = '0;
        offer(OP_VISIBLE, p);
        offer(OP_VISIBLE, ctx_pos(20));
        // durable against visible
        offer(OP_DURABLE, ctx_pos(25));
        p = ctx_pos(8);
        p.epoch = ~p.epoch;
        offer(OP_DURABLE, p);
        p = ctx_pos(20);
        p.frame = ~p.frame;
        offer(OP_DURABLE, p);
        offer(OP_DURABLE, ctx_pos(8));
        offer(OP_DURABLE, ctx_pos(8));
        offer(OP_DURABLE, ctx_pos(3));
        // projection and replicated against durable
        offer(OP_PROJECTION, ctx_pos(9));
        offer(OP_PROJECTION, ctx_pos(4));
        offer(OP_REPLICATED, ctx_pos(8));
        offer(OP_REPLICATED, ctx_pos(2));
        p = ctx_pos(4);
        p.stream = '1;
        offer(OP_PROJECTION, p);
        offer(OP_VISIBLE, ctx_pos(30));
        offer(OP_DURABLE, ctx_pos(25));
        // passes the dependency, unordered against itself; then all-zero and all-ones positions
        p = ctx_pos(8);
        p.frame = ~p.frame;
        offer(OP_REPLICATED, p);
        offer(OP_VISIBLE, '0);
        offer(OP_REPLICATED, '1);

        front = 40;
        for (int i = 0; i < RANDOM_OFFERS; i++)
        begin
            steady <= (i >= 600) && (i < 1000);
            front  = front + $urandom_range(0, 3);
            step   = front + $urandom_range(0, 16) - 12;
            p      = ctx_pos(step);
            op     = op_t'($urandom_range(0, 3));
            roll   = $urandom_range(0, 99);
            if (roll < 6)
            begin
                p.frame = {$urandom, $urandom};
            end
            else if (roll < 9)
            begin
                p.epoch = {$urandom, $urandom};
            end
            else if (roll < 12)
            begin
                p.stream = {$urandom, $urandom};
            end
            else if (roll < 15)
            begin
                p = {$urandom, $urandom, $urandom, $urandom,
                     $urandom, $urandom, $urandom, $urandom};
            end
            offer(op, p);
        end
        s_axis_tvalid <= 1'b0;
        steady        <= 1'b0;

        @(negedge clk);
        while (open_count != 0)
        begin
            @(negedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Offered %0d positions over all four watermarks: %0d advanced, %0d refused.",
                 offer_count, advance_count, refusal_count);
        $display("Mismatches found: %0d.", fail_count);
        if (fail_count == 0)
        begin
            $display("dependent_watermark_tracker_unit_tb passed");
        end
        else
        begin
            $display("dependent_watermark_tracker_unit_tb failed");
        end
        $finish;
    end

endmodule
